// ----- rtl/hpa_pkg.sv -----
// ============================================================================
// hpa_pkg: shared types and constants for the HSL pixel adjust block
// Holds the pixel transaction structs, register codes, sector and segment
// codes, and the table that maps an 8-bit channel to fixed point.
// ============================================================================
`default_nettype none

package hpa_pkg;

  // Default fraction width of the internal fixed-point format.
  localparam int FRAC_BITS_DEF = 16;
  // Widest fixed-point channel value the table can hold (FRAC_BITS up to 24).
  localparam int FX_MAX_W = 25;

  // Configuration port shape.
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 1'b1;

  // Gain of 1.0 with sixteen fraction bits.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;

  // Which HSL channel the gain scales.
  typedef enum logic [MODE_W-1:0] {
    MODE_HUE   = 2'd0,
    MODE_SAT   = 2'd1,
    MODE_LIGHT = 2'd2,
    MODE_NONE  = 2'd3
  } adjust_mode_t;

  // Which channel is the maximum when hue is formed.
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } hue_sect_t;

  // Piece of the hue-to-channel curve that a channel falls on.
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } chan_seg_t;

  // Input pixel transaction.
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_in;
  } pixel_in_t;

  // Result pixel transaction.
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;
  } pixel_out_t;

  typedef logic [255:0][FX_MAX_W-1:0] chan_table_t;

  // Table of (x * 2^frac_bits) / 255, truncated, built at elaboration.
  function automatic chan_table_t build_chan_table(int frac_bits);
    chan_table_t tbl;
    longint      v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) << frac_bits) / 255;
      tbl[i] = FX_MAX_W'(v);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hpa_div.sv -----
// ============================================================================
// hpa_div: pipelined fraction divider
// Computes (num * 2^FRAC_BITS) / den for num <= den, one quotient bit per
// register stage, FRAC_BITS+1 stages. A new division can enter every cycle.
// ============================================================================
`default_nettype none

module hpa_div import hpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int W         = FRAC_BITS_DEF + 2
) (
  input  logic             clk,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  output logic [FRAC_BITS:0] quo
);

  localparam int N = FRAC_BITS + 1;

  logic [W-1:0] rem [N];
  logic [W-1:0] dvs [N];
  logic [N-1:0] qb  [N];

  // First stage decides the integer bit of the quotient.
  always_ff @(posedge clk) begin
    if (num >= den) begin
      rem[0] <= num - den;
      qb[0]  <= N'(1);
    end else begin
      rem[0] <= num;
      qb[0]  <= '0;
    end
    dvs[0] <= den;
  end

  // Each later stage shifts the remainder and decides one fraction bit.
  for (genvar k = 1; k < N; k++) begin : g_stage
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem[k-1], 1'b0};
    assign ge    = trial >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      rem[k] <= ge ? W'(trial - {1'b0, dvs[k-1]}) : trial[W-1:0];
      dvs[k] <= dvs[k-1];
      qb[k]  <= {qb[k-1][N-2:0], ge};
    end
  end

  assign quo = qb[N-1];

endmodule

`default_nettype wire

// ----- rtl/hsl_pixel_adjust_top.sv -----
// ============================================================================
// hsl_pixel_adjust_top: per-pixel hue, saturation or lightness adjustment
// Converts RGB to fixed-point HSL, scales one channel or none, converts back.
// ============================================================================
// Usage:
//   A pixel transaction is taken at a rising edge where start is high and
//   busy is low. busy is high only during reset, so one pixel per clock is
//   accepted with no gaps.
//   Each pixel gives one result transaction: done is high for exactly one
//   cycle with the adjusted pixel on result, and last_out follows last_in.
//   The pipeline is the two pipelined dividers, with one quotient bit per
//   stage, plus ten arithmetic stages around them. Throughput is one
//   pixel per cycle. The receiver cannot stall; results leave on their
//   fixed cycle.
//   Reset clears all pipeline valid bits, so pixels in flight are dropped,
//   and sets adjust_mode to lightness and gain to 1.0.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant to be made while no pixel is in flight.
// ============================================================================
`default_nettype none

module hsl_pixel_adjust_top import hpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pixel_in_t             pixel,
  output logic                  done,
  output pixel_out_t            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int CW   = F + 1;          // channel, saturation, quotient
  localparam int SW   = F + 2;          // sums and divider operands
  localparam int LW   = F + 2;          // lightness after gain
  localparam int MAGW = F + 3;          // hue before the divide by six
  localparam int KSH  = F + 4;
  localparam int MW   = F + 2;          // reciprocal of six
  localparam int TW   = F + 6;          // signed t1, t2 and their difference
  localparam int AW   = TW + 3;
  localparam int PW   = AW + CW + 1;
  localparam int N    = F + 1;          // divider stages
  localparam int LAT  = F + 11;

  localparam longint ONE  = longint'(1) << F;
  localparam longint HALF = ONE / 2;
  localparam longint T3   = ONE / 3;
  localparam longint T6   = ONE / 6;
  localparam longint T23  = (2 * ONE) / 3;
  localparam longint M6   = (longint'(1) << KSH) / 6;

  localparam chan_table_t CTAB = build_chan_table(FRAC_BITS);

  typedef struct packed {
    logic            last;
    logic            grey;
    logic            hneg;
    hue_sect_t       sect;
    logic [CW-1:0]   l;
  } side_t;

  // Configuration registers.
  adjust_mode_t      adjust_mode;
  logic [GAIN_W-1:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_mode <= MODE_LIGHT;
      gain        <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADJUST_MODE: adjust_mode <= adjust_mode_t'(cfg_data[MODE_W-1:0]);
        REG_GAIN:        gain        <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // Valid bits of every stage.
  logic          s1_valid, s2_valid, h1_valid, h2_valid;
  logic          m1_valid, m2_valid, t1_valid, t2_valid, c1_valid;
  logic [N-1:0]  dv;

  // ---- Stage 1: channels to fixed point.
  logic [CW-1:0] s1_r, s1_g, s1_b;
  logic          s1_last;

  always_ff @(posedge clk) begin
    s1_r    <= CW'(CTAB[pixel.red_in]);
    s1_g    <= CW'(CTAB[pixel.green_in]);
    s1_b    <= CW'(CTAB[pixel.blue_in]);
    s1_last <= pixel.last_in;
  end

  // ---- Stage 2: max, min, lightness and divider operands.
  logic [CW-1:0] mx, mn, dif, hmag, lmid;
  logic [SW-1:0] sum, sden;
  logic          hneg, grey;
  hue_sect_t     sect;

  always_comb begin
    mx = s1_r;
    if (s1_g > mx) mx = s1_g;
    if (s1_b > mx) mx = s1_b;
    mn = s1_r;
    if (s1_g < mn) mn = s1_g;
    if (s1_b < mn) mn = s1_b;
    dif  = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    lmid = sum[SW-1:1];
    sden = (lmid < CW'(HALF)) ? sum : SW'(2 * ONE) - sum;
    grey = (s1_r == s1_g) && (s1_g == s1_b);
    // Hue numerator sign and magnitude, red tested first.
    if (s1_r == mx) begin
      sect = SECT_RED;
      hneg = s1_g < s1_b;
      hmag = hneg ? s1_b - s1_g : s1_g - s1_b;
    end else if (s1_g == mx) begin
      sect = SECT_GREEN;
      hneg = s1_b < s1_r;
      hmag = hneg ? s1_r - s1_b : s1_b - s1_r;
    end else begin
      sect = SECT_BLUE;
      hneg = s1_r < s1_g;
      hmag = hneg ? s1_g - s1_r : s1_r - s1_g;
    end
  end

  logic [SW-1:0] s2_snum, s2_sden, s2_hnum, s2_hden;
  side_t         s2_side;

  always_ff @(posedge clk) begin
    s2_snum <= SW'(dif);
    s2_sden <= sden;
    s2_hnum <= SW'(hmag);
    s2_hden <= SW'(dif);
    s2_side <= '{last: s1_last, grey: grey, hneg: hneg, sect: sect, l: lmid};
  end

  // ---- Divider stages: saturation and hue fraction.
  logic [CW-1:0] s_quo, h_quo;
  side_t         side_dly [N];

  hpa_div #(.FRAC_BITS(FRAC_BITS), .W(SW)) u_sat_div (
    .clk (clk),
    .num (s2_snum),
    .den (s2_sden),
    .quo (s_quo)
  );

  hpa_div #(.FRAC_BITS(FRAC_BITS), .W(SW)) u_hue_div (
    .clk (clk),
    .num (s2_hnum),
    .den (s2_hden),
    .quo (h_quo)
  );

  // Side data follows the dividers.
  always_ff @(posedge clk) begin
    side_dly[0] <= s2_side;
    for (int k = 1; k < N; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  // ---- Stage H1: hue in sixths, times the reciprocal of six.
  side_t           dside;
  logic [MAGW-1:0] hbase, hval;
  logic            hval_neg;

  always_comb begin
    dside = side_dly[N-1];
    case (dside.sect)
      SECT_GREEN: hbase = MAGW'(2 * ONE);
      SECT_BLUE:  hbase = MAGW'(4 * ONE);
      default:    hbase = '0;
    endcase
    if (dside.sect == SECT_RED) begin
      hval     = MAGW'(h_quo);
      hval_neg = dside.hneg && (h_quo != '0);
    end else begin
      hval     = dside.hneg ? hbase - MAGW'(h_quo) : hbase + MAGW'(h_quo);
      hval_neg = 1'b0;
    end
  end

  logic [MAGW-1:0]      h1_mag;
  logic [MAGW+MW-1:0]   h1_prod;
  logic                 h1_neg, h1_grey, h1_last;
  logic [CW-1:0]        h1_s, h1_l;

  always_ff @(posedge clk) begin
    h1_mag  <= hval;
    h1_prod <= (MAGW+MW)'(hval) * (MAGW+MW)'(M6);
    h1_neg  <= hval_neg;
    h1_grey <= dside.grey;
    h1_last <= dside.last;
    h1_s    <= s_quo;
    h1_l    <= dside.l;
  end

  // ---- Stage H2: finish the divide by six and wrap negative hue.
  logic [MAGW-1:0] q0, q6;
  logic [MAGW+2:0] hrem;
  logic [F-1:0]    hfin;

  always_comb begin
    q0   = MAGW'(h1_prod >> KSH);
    hrem = (MAGW+3)'(h1_mag) - (MAGW+3)'(q0) * (MAGW+3)'(6);
    q6   = (hrem >= (MAGW+3)'(6)) ? q0 + MAGW'(1) : q0;
    if (h1_grey) begin
      hfin = '0;
    end else if (h1_neg && (q6 != '0)) begin
      hfin = F'(MAGW'(ONE) - q6);
    end else begin
      hfin = F'(q6);
    end
  end

  logic [F-1:0]  h2_h;
  logic [CW-1:0] h2_s, h2_l;
  logic          h2_last;

  always_ff @(posedge clk) begin
    h2_h    <= hfin;
    h2_s    <= h1_grey ? '0 : h1_s;
    h2_l    <= h1_l;
    h2_last <= h1_last;
  end

  // ---- Stage M1: multiply the selected channel by the gain.
  logic [CW-1:0] gop;

  always_comb begin
    case (adjust_mode)
      MODE_HUE: gop = CW'(h2_h);
      MODE_SAT: gop = h2_s;
      default:  gop = h2_l;
    endcase
  end

  logic [CW+GAIN_W-1:0] m1_prod;
  logic [F-1:0]         m1_h;
  logic [CW-1:0]        m1_s, m1_l;
  logic                 m1_last;

  always_ff @(posedge clk) begin
    m1_prod <= (CW+GAIN_W)'(gop) * (CW+GAIN_W)'(gain);
    m1_h    <= h2_h;
    m1_s    <= h2_s;
    m1_l    <= h2_l;
    m1_last <= h2_last;
  end

  // ---- Stage M2: wrap hue, clamp saturation, keep lightness unclamped.
  logic [CW+1:0] scaled;
  logic [F-1:0]  mh;
  logic [CW-1:0] ms;
  logic [LW-1:0] ml;

  always_comb begin
    scaled = (CW+2)'(m1_prod >> 16);
    mh     = m1_h;
    ms     = m1_s;
    ml     = LW'(m1_l);
    case (adjust_mode)
      MODE_HUE:   mh = scaled[F-1:0];
      MODE_SAT:   ms = (scaled > (CW+2)'(ONE)) ? CW'(ONE) : CW'(scaled);
      MODE_LIGHT: ml = LW'(scaled);
      default: ;
    endcase
  end

  logic [F-1:0]  m2_h;
  logic [CW-1:0] m2_s;
  logic [LW-1:0] m2_l;
  logic          m2_last;

  always_ff @(posedge clk) begin
    m2_h    <= mh;
    m2_s    <= ms;
    m2_l    <= ml;
    m2_last <= m1_last;
  end

  // ---- Stage T1: lightness times (1 + s) or s.
  logic          lo_half;
  logic [F+1:0]  lmul;

  always_comb begin
    lo_half = m2_l < LW'(HALF);
    lmul    = lo_half ? (F+2)'(ONE) + (F+2)'(m2_s) : (F+2)'(m2_s);
  end

  logic [LW+F+1:0] t1_prod;
  logic [F-1:0]    t1_h;
  logic [CW-1:0]   t1_s;
  logic [LW-1:0]   t1_l;
  logic            t1_lo, t1_last;

  always_ff @(posedge clk) begin
    t1_prod <= (LW+F+2)'(m2_l) * (LW+F+2)'(lmul);
    t1_h    <= m2_h;
    t1_s    <= m2_s;
    t1_l    <= m2_l;
    t1_lo   <= lo_half;
    t1_last <= m2_last;
  end

  // ---- Stage T2: temp values and the three hue offsets.
  logic [LW+1:0]        ls;
  logic [TW-2:0]        t2u;
  logic signed [TW-1:0] t2s, t1s;
  logic [CW-1:0]        tr, tg, tb, trs;

  always_comb begin
    ls  = (LW+2)'(t1_prod >> F);
    t2u = t1_lo ? (TW-1)'(ls)
                : (TW-1)'(t1_l) + (TW-1)'(t1_s) - (TW-1)'(ls);
    t2s = $signed({1'b0, t2u});
    t1s = TW'($signed({1'b0, t1_l, 1'b0})) - t2s;
    // Red offset: one third ahead, wrapped only above one.
    trs = CW'(t1_h) + CW'(T3);
    tr  = (trs > CW'(ONE)) ? trs - CW'(ONE) : trs;
    tg  = CW'(t1_h);
    // Blue offset: one third behind, truncated toward zero, then wrapped.
    if (CW'(t1_h) < CW'(T3)) begin
      tb = CW'(t1_h) + CW'(ONE - T3);
    end else if (CW'(t1_h) == CW'(T3)) begin
      tb = '0;
    end else begin
      tb = CW'(t1_h) - CW'(T3 + 1);
    end
  end

  logic signed [TW-1:0] t2_t1, t2_t2;
  logic [CW-1:0]        t2_tc [3];
  logic                 t2_last;

  always_ff @(posedge clk) begin
    t2_t1    <= t1s;
    t2_t2    <= t2s;
    t2_tc[0] <= tr;
    t2_tc[1] <= tg;
    t2_tc[2] <= tb;
    t2_last  <= t1_last;
  end

  // ---- Stage C1: one multiply per color lane on the sloped segments.
  logic signed [TW-1:0] tdiff;
  assign tdiff = t2_t2 - t2_t1;

  chan_seg_t            c1_seg  [3];
  logic signed [PW-1:0] c1_prod [3];
  logic signed [TW-1:0] c1_t1, c1_t2;
  logic                 c1_last;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    chan_seg_t            seg;
    logic signed [AW-1:0] opa;
    logic signed [CW:0]   opb;

    always_comb begin
      if (t2_tc[c] < CW'(T6)) begin
        seg = SEG_RISE;
      end else if (t2_tc[c] < CW'(HALF)) begin
        seg = SEG_HIGH;
      end else if (t2_tc[c] < CW'(T23)) begin
        seg = SEG_FALL;
      end else begin
        seg = SEG_LOW;
      end
      case (seg)
        SEG_RISE: begin
          opa = (AW'(tdiff) <<< 2) + (AW'(tdiff) <<< 1);
          opb = $signed({1'b0, t2_tc[c]});
        end
        SEG_FALL: begin
          opa = AW'(tdiff);
          opb = $signed({1'b0, CW'(T23) - t2_tc[c]});
        end
        default: begin
          opa = '0;
          opb = '0;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      c1_seg[c]  <= seg;
      c1_prod[c] <= PW'(opa) * PW'(opb);
    end
  end

  always_ff @(posedge clk) begin
    c1_t1   <= t2_t1;
    c1_t2   <= t2_t2;
    c1_last <= t2_last;
  end

  // ---- Stage C2: channel value and conversion to a byte.
  logic [7:0] byte_out [3];

  for (genvar c = 0; c < 3; c++) begin : g_byte
    logic signed [PW-1:0] sh, cv;
    logic [F+7:0]         scl;

    always_comb begin
      sh = c1_prod[c] >>> F;
      case (c1_seg[c])
        SEG_RISE: cv = PW'(c1_t1) + sh;
        SEG_FALL: cv = PW'(c1_t1) + (sh <<< 2) + (sh <<< 1);
        SEG_HIGH: cv = PW'(c1_t2);
        default:  cv = PW'(c1_t1);
      endcase
      scl = {cv[F-1:0], 8'd0} - (F+8)'(cv[F-1:0]);
      if (cv >= ONE) begin
        byte_out[c] = 8'd255;
      end else if (cv < 0) begin
        byte_out[c] = 8'd0;
      end else begin
        byte_out[c] = scl[F+7:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.red_out   <= byte_out[0];
    result.green_out <= byte_out[1];
    result.blue_out  <= byte_out[2];
    result.last_out  <= c1_last;
  end

  // Valid bits travel beside the data; reset drops pixels in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      dv       <= '0;
      h1_valid <= 1'b0;
      h2_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      c1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      dv       <= {dv[N-2:0], s2_valid};
      h1_valid <= dv[N-1];
      h2_valid <= h1_valid;
      m1_valid <= h2_valid;
      m2_valid <= m1_valid;
      t1_valid <= m2_valid;
      t2_valid <= t1_valid;
      c1_valid <= t2_valid;
      done     <= c1_valid;
    end
  end

  // Every accepted pixel gives a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted pixel produced no result at the expected cycle");

  // No result appears without a pixel accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching accepted pixel");

  // The end-of-image mark follows its own pixel through the pipeline.
  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.last_out == $past(pixel.last_in, LAT)))
    else $error("last_out does not match last_in of the same pixel");

endmodule

`default_nettype wire

// ----- sim/hsl_pixel_adjust_top_test.sv -----
// ============================================================================
// hsl_pixel_adjust_top_test: self-checking bench for the HSL pixel adjuster
// Drives pixel transactions with random gaps, predicts each adjusted pixel
// with a bit-true fixed-point model and checks results in order through a
// small scoreboard, across several mode and gain settings.
// ============================================================================
`default_nettype none

module hsl_pixel_adjust_top_test;
  import hpa_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int LATENCY = FB + 11;
  localparam longint CYCLE_LIMIT = 400000;

  // Scoreboard: predicts adjusted pixels and checks results in order.
  class pixel_scoreboard;
    pixel_out_t   pending_pixels[$];
    adjust_mode_t mode;
    logic [GAIN_W-1:0] gain;
    int errors;

    function longint fx_shr(longint v);
      if (v >= 0) return v >>> FB;
      return -((-v - 1) >>> FB) - 1;
    endfunction

    function longint fx_div(longint a, longint b);
      return (a * ONE) / b;
    endfunction

    // Picks a channel value from the piecewise hue curve.
    function longint hue_channel(longint t, longint t1, longint t2);
      if (t < ONE / 6) return t1 + fx_shr((t2 - t1) * 6 * t);
      if (t < ONE / 2) return t2;
      if (t < (2 * ONE) / 3) return t1 + fx_shr((t2 - t1) * ((2 * ONE) / 3 - t)) * 6;
      return t1;
    endfunction

    function logic [7:0] to_byte(longint c);
      if (c >= ONE) return 8'd255;
      if (c < 0) return 8'd0;
      return 8'((c * 255) >>> FB);
    endfunction

    function pixel_out_t adjust_pixel(pixel_in_t p);
      longint r, g, b, mx, mn, h, s, l, d, t1, t2, tr, tb;
      pixel_out_t q;
      r = (longint'(p.red_in) * ONE) / 255;
      g = (longint'(p.green_in) * ONE) / 255;
      b = (longint'(p.blue_in) * ONE) / 255;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (r == g && g == b) begin
        h = 0; s = 0; l = r;
      end else begin
        d = mx - mn;
        l = (mn + mx) / 2;
        if (l < ONE / 2) s = fx_div(d, mx + mn);
        else s = fx_div(d, 2 * ONE - mx - mn);
        if (r == mx) h = fx_div(g - b, d);
        else if (g == mx) h = 2 * ONE + fx_div(b - r, d);
        else h = 4 * ONE + fx_div(r - g, d);
        h = h / 6;
        if (h < 0) h += ONE;
      end
      case (mode)
        MODE_HUE: begin
          h = (h * longint'(gain)) >>> 16;
          h = h % ONE;
        end
        MODE_SAT: begin
          s = (s * longint'(gain)) >>> 16;
          if (s > ONE) s = ONE;
        end
        MODE_LIGHT: l = (l * longint'(gain)) >>> 16;
        default: ;
      endcase
      if (l < ONE / 2) t2 = fx_shr(l * (ONE + s));
      else t2 = (l + s) - fx_shr(l * s);
      t1 = 2 * l - t2;
      tr = h + ONE / 3;
      if (tr > ONE) tr -= ONE;
      tb = (3 * h - ONE) / 3;
      if (tb < 0) tb += ONE;
      q.red_out   = to_byte(hue_channel(tr, t1, t2));
      q.green_out = to_byte(hue_channel(h, t1, t2));
      q.blue_out  = to_byte(hue_channel(tb, t1, t2));
      q.last_out  = p.last_in;
      return q;
    endfunction

    function void note_pixel(pixel_in_t p);
      pending_pixels.push_back(adjust_pixel(p));
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result: expected r=%0d g=%0d b=%0d l=%0d got r=%0d g=%0d b=%0d l=%0d",
                   want.red_out, want.green_out, want.blue_out, want.last_out,
                   got.red_out, got.green_out, got.blue_out, got.last_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pixel_in_t pixel = '0;
  logic done;
  pixel_out_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ADJUST_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard board = new();
  longint cycle_count = 0;
  int gap_pct = 0;

  hsl_pixel_adjust_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result monitor and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) board.check_result(result);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsl_pixel_adjust_top: mismatch");
      $finish;
    end
  end

  // Writes one register while the pipeline is empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ADJUST_MODE) board.mode = adjust_mode_t'(val[MODE_W-1:0]);
    else board.gain = val[GAIN_W-1:0];
  endtask

  // Sends one pixel transaction, with a random idle gap first.
  task automatic send_pixel(pixel_in_t p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_pixel(p);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (board.pending_pixels.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    int kind;
    kind = $urandom_range(9);
    p.red_in = 8'($urandom_range(255));
    p.green_in = 8'($urandom_range(255));
    p.blue_in = 8'($urandom_range(255));
    p.last_in = 1'($urandom_range(1));
    if (kind == 0) begin
      p.green_in = p.red_in;
      p.blue_in = p.red_in;
    end else if (kind == 1) begin
      p.green_in = p.red_in;
    end else if (kind == 2) begin
      p.red_in = {8{p.red_in[0]}};
      p.green_in = {8{p.green_in[0]}};
      p.blue_in = {8{p.blue_in[0]}};
    end
    return p;
  endfunction

  // Directed pixels: extremes, greys, each sector and ties between channels.
  task automatic directed_pixels;
    send_pixel('{8'd0, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd255, 8'd255, 8'd255, 1'b1});
    send_pixel('{8'd128, 8'd128, 8'd128, 1'b0});
    send_pixel('{8'd255, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd0, 8'd255, 8'd0, 1'b1});
    send_pixel('{8'd0, 8'd0, 8'd255, 1'b0});
    send_pixel('{8'd255, 8'd255, 8'd0, 1'b0});
    send_pixel('{8'd0, 8'd255, 8'd255, 1'b1});
    send_pixel('{8'd255, 8'd0, 8'd255, 1'b0});
    send_pixel('{8'd200, 8'd10, 8'd90, 1'b0});
    send_pixel('{8'd30, 8'd40, 8'd250, 1'b1});
    send_pixel('{8'd1, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd254, 8'd255, 8'd255, 1'b0});
    send_pixel('{8'd170, 8'd85, 8'd255, 1'b1});
  endtask

  // One phase: a register setting, directed pixels, then random ones.
  task automatic run_phase(adjust_mode_t m, logic [GAIN_W-1:0] gv, int count);
    write_reg(REG_ADJUST_MODE, CFG_DATA_W'(m));
    write_reg(REG_GAIN, CFG_DATA_W'(gv));
    directed_pixels();
    repeat (count) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    board.mode = MODE_LIGHT;
    board.gain = GAIN_RESET;
    board.errors = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting first, with the sender idling now and then.
    gap_pct = 6;
    directed_pixels();
    repeat (120) send_pixel(rand_pixel());
    drain();

    run_phase(MODE_HUE, 18'd131072, 110);
    run_phase(MODE_HUE, 18'd0, 60);
    run_phase(MODE_HUE, 18'($urandom_range(131072)), 110);
    run_phase(MODE_SAT, 18'd131072, 110);
    gap_pct = 79;
    run_phase(MODE_SAT, 18'd0, 60);
    run_phase(MODE_SAT, 18'($urandom_range(131072)), 110);
    run_phase(MODE_LIGHT, 18'd131072, 110);
    run_phase(MODE_LIGHT, 18'd0, 60);
    gap_pct = 0;
    run_phase(MODE_LIGHT, 18'($urandom_range(131072)), 110);
    run_phase(MODE_NONE, 18'($urandom_range(131072)), 100);
    run_phase(MODE_HUE, 18'h3FFFF, 90);
    run_phase(MODE_SAT, 18'h3FFFF, 90);
    run_phase(MODE_LIGHT, 18'h3FFFF, 90);
    run_phase(MODE_HUE, 18'($urandom_range(262143)), 80);

    if (board.errors == 0 && board.pending_pixels.size() == 0) begin
      $display("hsl_pixel_adjust_top: match");
    end else begin
      $display("hsl_pixel_adjust_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- hsl_pixel_adjust_top.f -----
rtl/hpa_pkg.sv
rtl/hpa_div.sv
rtl/hsl_pixel_adjust_top.sv
sim/hsl_pixel_adjust_top_test.sv
